/* hw/rtl/lsrs_pkg.sv */
// ----------------------------------------------------------------------------
// lsrs_pkg: shared types and constants
// Widths and the sequencer state type for the 2x2 rational solver.
// ----------------------------------------------------------------------------
package lsrs_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int NUM_WIDTH  = 2 * COEF_WIDTH + 1;
  localparam int DEN_WIDTH  = 2 * COEF_WIDTH;
  localparam int CNT_WIDTH  = $clog2(DEN_WIDTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_NEXT,
    ST_DONE
  } state_t;

  // Command from the sequencer to the shared divide unit.
  typedef struct packed {
    logic                 start;
    logic [DEN_WIDTH-1:0] dividend;
    logic [DEN_WIDTH-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic                 done;
    logic [DEN_WIDTH-1:0] quotient;
    logic [DEN_WIDTH-1:0] remainder;
  } div_rsp_t;

endpackage

/* hw/rtl/linear_system_2x2_rational_solver.sv */
// ----------------------------------------------------------------------------
// linear_system_2x2_rational_solver: exact 2x2 solver by Cramer's rule
// Gives x and y as reduced fractions, sign on the numerator.
// ----------------------------------------------------------------------------
// Usage: the input channel carries the six coefficients of
// a1*x+b1*y=c1 and a2*x+b2*y=c2 as one transaction (in_valid/in_stall).
// The output channel carries the reduced fractions and the singular flag
// (out_valid/out_stall). The block works on one transaction at a time:
// in_stall is high from acceptance until the result has been taken.
// Flow: two products per cycle in three steps, then per component one
// setup state, a Euclidean GCD on the shared divider, two exact divides
// by the GCD and one state to store the fraction. The GCD takes k Euclid
// steps (k is at most about 46 for 32-bit magnitudes). A component with a
// zero numerator skips the divides; a singular system skips them and goes
// from the x component straight to the result. Reset (rst, synchronous)
// returns the sequencer to idle and drops out_valid. While out_stall is high
// the result is held unchanged and no new transaction is taken.
module linear_system_2x2_rational_solver (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lsrs_pkg::COEF_WIDTH-1:0] coef_a1,
  input  logic signed [lsrs_pkg::COEF_WIDTH-1:0] coef_b1,
  input  logic signed [lsrs_pkg::COEF_WIDTH-1:0] const_c1,
  input  logic signed [lsrs_pkg::COEF_WIDTH-1:0] coef_a2,
  input  logic signed [lsrs_pkg::COEF_WIDTH-1:0] coef_b2,
  input  logic signed [lsrs_pkg::COEF_WIDTH-1:0] const_c2,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lsrs_pkg::NUM_WIDTH-1:0]  x_numerator,
  output logic [lsrs_pkg::DEN_WIDTH-1:0]         x_denominator,
  output logic signed [lsrs_pkg::NUM_WIDTH-1:0]  y_numerator,
  output logic [lsrs_pkg::DEN_WIDTH-1:0]         y_denominator,
  output logic                                singular
);

  localparam int CW = lsrs_pkg::COEF_WIDTH;
  localparam int NW = lsrs_pkg::NUM_WIDTH;
  localparam int DW = lsrs_pkg::DEN_WIDTH;

  lsrs_pkg::state_t state, state_next;

  // Captured coefficients.
  logic signed [CW-1:0] a1, b1, c1, a2, b2, c2;
  // Step of the product phase: one determinant (two products) per step.
  logic [1:0] mstep;
  logic signed [NW-1:0] det, xn, yn;

  // Working registers for the component in progress.
  logic          comp;      // 0 for x, 1 for y
  logic [DW-1:0] nmag, dmag, gp, gq, gval;
  logic          neg;

  lsrs_pkg::div_cmd_t cmd;
  lsrs_pkg::div_rsp_t rsp;

  lsrs_div u_div (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  // One pair of multipliers shared across the product steps.
  logic signed [CW-1:0]   m0a, m0b, m1a, m1b;
  logic signed [2*CW-1:0] p0, p1;
  logic signed [NW-1:0]   pdiff;

  always_comb begin
    unique case (mstep)
      2'd0: begin m0a = a1; m0b = b2; m1a = a2; m1b = b1; end
      2'd1: begin m0a = c1; m0b = b2; m1a = b1; m1b = c2; end
      default: begin m0a = a1; m0b = c2; m1a = c1; m1b = a2; end
    endcase
    p0    = m0a * m0b;
    p1    = m1a * m1b;
    pdiff = NW'(p0) - NW'(p1);
  end

  // Current numerator and its magnitude.
  logic signed [NW-1:0] cur_num;
  logic [NW-1:0]        num_abs, det_abs;
  assign cur_num = comp ? yn : xn;
  assign num_abs = cur_num[NW-1] ? NW'(-cur_num) : cur_num;
  assign det_abs = det[NW-1] ? NW'(-det) : det;

  always_comb begin
    state_next = state;
    cmd.start    = 1'b0;
    cmd.dividend = gp;
    cmd.divisor  = gq;
    unique case (state)
      lsrs_pkg::ST_IDLE:  if (in_valid) state_next = lsrs_pkg::ST_MUL;
      lsrs_pkg::ST_MUL:   if (mstep == 2'd2) state_next = lsrs_pkg::ST_CHECK;
      lsrs_pkg::ST_CHECK: begin
        if (det == '0 || num_abs == '0) begin
          state_next = lsrs_pkg::ST_NEXT;
        end else begin
          state_next = lsrs_pkg::ST_GCD;
          cmd.start    = 1'b1;
          cmd.dividend = num_abs[DW-1:0];
          cmd.divisor  = det_abs[DW-1:0];
        end
      end
      lsrs_pkg::ST_GCD: begin
        if (rsp.done) begin
          if (rsp.remainder == '0) begin
            state_next   = lsrs_pkg::ST_DIVN;
            cmd.start    = 1'b1;
            cmd.dividend = nmag;
            cmd.divisor  = gq;
          end else begin
            cmd.start    = 1'b1;
            cmd.dividend = gq;
            cmd.divisor  = rsp.remainder;
          end
        end
      end
      lsrs_pkg::ST_DIVN: begin
        if (rsp.done) begin
          state_next   = lsrs_pkg::ST_DIVD;
          cmd.start    = 1'b1;
          cmd.dividend = dmag;
          cmd.divisor  = gval;
        end
      end
      lsrs_pkg::ST_DIVD: if (rsp.done) state_next = lsrs_pkg::ST_NEXT;
      lsrs_pkg::ST_NEXT:
        state_next = (comp || det == '0) ? lsrs_pkg::ST_DONE : lsrs_pkg::ST_CHECK;
      lsrs_pkg::ST_DONE:  if (!out_stall) state_next = lsrs_pkg::ST_IDLE;
      default:            state_next = lsrs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divisor register of Euclid: tracks the last divisor handed to the unit.
  assign gval = gq;

  logic [NW-1:0] res_num;
  logic [DW-1:0] res_den;

  always_ff @(posedge clk) begin
    if (state == lsrs_pkg::ST_IDLE && in_valid) begin
      a1 <= coef_a1; b1 <= coef_b1; c1 <= const_c1;
      a2 <= coef_a2; b2 <= coef_b2; c2 <= const_c2;
      mstep <= 2'd0;
      comp  <= 1'b0;
    end
    if (state == lsrs_pkg::ST_MUL) begin
      unique case (mstep)
        2'd0:    det <= pdiff;
        2'd1:    xn  <= pdiff;
        default: yn  <= pdiff;
      endcase
      mstep <= mstep + 2'd1;
    end
    if (cmd.start) begin
      gp <= cmd.dividend;
      gq <= cmd.divisor;
    end
    if (state == lsrs_pkg::ST_CHECK) begin
      nmag <= num_abs[DW-1:0];
      dmag <= det_abs[DW-1:0];
      neg  <= cur_num[NW-1] ^ det[NW-1];
      res_num <= '0;
      res_den <= DW'(1);
    end
    // Exact divide results; gq holds the gcd during these divides.
    if (state == lsrs_pkg::ST_DIVN && rsp.done) begin
      res_num <= neg ? NW'(-{1'b0, rsp.quotient}) : {1'b0, rsp.quotient};
    end
    if (state == lsrs_pkg::ST_DIVD && rsp.done) begin
      res_den <= rsp.quotient;
    end
    if (state == lsrs_pkg::ST_NEXT) begin
      if (!comp) begin
        x_numerator   <= res_num;
        x_denominator <= res_den;
        comp          <= 1'b1;
      end else begin
        y_numerator   <= res_num;
        y_denominator <= res_den;
      end
      if (det == '0) begin
        x_numerator   <= '0;
        x_denominator <= DW'(1);
        y_numerator   <= '0;
        y_denominator <= DW'(1);
      end
      singular <= (det == '0);
    end
  end

  assign in_stall  = (state != lsrs_pkg::ST_IDLE);
  assign out_valid = (state == lsrs_pkg::ST_DONE);

endmodule

/* hw/rtl/lsrs_div.sv */
// ----------------------------------------------------------------------------
// lsrs_div: shared restoring divider
// Unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsrs_div (
  input  logic              clk,
  input  logic              rst,
  input  lsrs_pkg::div_cmd_t cmd,
  output lsrs_pkg::div_rsp_t rsp
);

  logic                           busy;
  logic [lsrs_pkg::CNT_WIDTH-1:0] count;
  logic [lsrs_pkg::DEN_WIDTH-1:0] quo;
  logic [lsrs_pkg::DEN_WIDTH-1:0] rem;
  logic [lsrs_pkg::DEN_WIDTH-1:0] dvs;
  logic [lsrs_pkg::DEN_WIDTH:0]   trial;
  logic [lsrs_pkg::DEN_WIDTH:0]   shifted;
  logic                           done;

  assign shifted = {rem, quo[lsrs_pkg::DEN_WIDTH-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy  <= 1'b1;
        count <= lsrs_pkg::CNT_WIDTH'(lsrs_pkg::DEN_WIDTH);
        quo   <= cmd.dividend;
        rem   <= '0;
        dvs   <= cmd.divisor;
      end else if (busy) begin
        if (!trial[lsrs_pkg::DEN_WIDTH]) begin
          rem <= trial[lsrs_pkg::DEN_WIDTH-1:0];
          quo <= {quo[lsrs_pkg::DEN_WIDTH-2:0], 1'b1};
        end else begin
          rem <= shifted[lsrs_pkg::DEN_WIDTH-1:0];
          quo <= {quo[lsrs_pkg::DEN_WIDTH-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == lsrs_pkg::CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
